/* rtl/cda_pkg.sv */
package cda_pkg;

  // width of the shared remainder / accumulator datapath
  localparam int UW = 23;
  // width of a signed day number
  localparam int DW = UW + 1;

  localparam int YEAR_MAX = 9999;
  localparam int DIST_MAX = 4194303;
  // days from 0000-01-01 to 0001-01-01
  localparam int DAYS_TO_Y1 = 366;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_DIFF = 2'd2;
  localparam logic [1:0] OP_CMP  = 2'd3;

  localparam logic [1:0] REL_EQ = 2'd0;
  localparam logic [1:0] REL_LT = 2'd1;
  localparam logic [1:0] REL_GT = 2'd2;

  localparam logic [3:0] LAST_STEP = 4'd14;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  typedef struct packed {
    logic          load;
    logic          step;
    logic [UW-1:0] rem_init;
    logic [UW-1:0] divisor;
    logic [UW-1:0] addend;
  } unit_ctl_t;

  typedef struct packed {
    logic [UW-1:0] divisor;
    logic [UW-1:0] addend;
  } step_const_t;

  // restoring division schedule over 400, 100, 4 and 1 year blocks
  // years -> days when to_date is low, days -> years when it is high
  function automatic step_const_t step_const(logic to_date, logic [3:0] s);
    step_const_t c;
    logic [UW-1:0] base_y;
    logic [UW-1:0] base_d;
    logic [2:0] sh;
    if (s < 4'd6) begin
      base_y = UW'(400);
      base_d = UW'(146097);
      sh = 3'(4'd5 - s);
    end else if (s < 4'd8) begin
      base_y = UW'(100);
      base_d = UW'(36524);
      sh = 3'(4'd7 - s);
    end else if (s < 4'd13) begin
      base_y = UW'(4);
      base_d = UW'(1461);
      sh = 3'(4'd12 - s);
    end else begin
      base_y = UW'(1);
      base_d = UW'(365);
      sh = 3'(LAST_STEP - s);
    end
    if (to_date) begin
      c.divisor = base_d << sh;
      c.addend  = base_y << sh;
    end else begin
      c.divisor = base_y << sh;
      c.addend  = base_d << sh;
    end
    return c;
  endfunction

  function automatic logic [3:0] clamp_month(logic [3:0] m);
    logic [3:0] r;
    if (m == 4'd0) begin
      r = 4'd1;
    end else if (m > 4'd12) begin
      r = 4'd12;
    end else begin
      r = m;
    end
    return r;
  endfunction

  // days before the first of month m (1..12) in a common year
  function automatic logic [8:0] cum_days(logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // length of month, index from 0 for january
  function automatic logic [4:0] month_len(logic [3:0] idx, logic leap);
    logic [4:0] r;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: r = 5'd31;
      4'd1:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd30;
    endcase
    return r;
  endfunction

endpackage

/* rtl/cda_unit.sv */
module cda_unit (
  input  logic                    clk,
  input  cda_pkg::unit_ctl_t      ctl,
  output logic [cda_pkg::UW-1:0]  rem,
  output logic [cda_pkg::UW-1:0]  acc,
  output logic                    take
);
  import cda_pkg::*;

  logic [UW-1:0] rem_r, rem_nxt;
  logic [UW-1:0] acc_r, acc_nxt;
  logic [UW:0]   diff;

  // compare and subtract in one go, carry out says whether it fits
  assign diff = {1'b0, rem_r} - {1'b0, ctl.divisor};
  assign take = ~diff[UW];

  always_comb begin
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    if (ctl.load) begin
      rem_nxt = ctl.rem_init;
      acc_nxt = '0;
    end else if (ctl.step && take) begin
      rem_nxt = diff[UW-1:0];
      acc_nxt = acc_r + ctl.addend;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
  end

  assign rem = rem_r;
  assign acc = acc_r;

endmodule

/* rtl/calendar_date_arithmetic_top.sv */
// Gregorian date add, subtract, difference and compare. One item is taken at a
// time. The conversions share one compare-subtract unit: each date is converted
// to a day number in 15 steps over 400/100/4/1 year blocks, a day number goes
// back to a year in another 15 steps, and the month is found by stepping one
// month per cycle. A date in year 0 skips its 15 conversion steps and a shift
// that leaves the year range stops before the month search, so those items
// finish sooner. The result sits in an output register, so a new item is taken
// while an earlier result still waits for the receiver; a finished result that
// finds that register still full waits until it is free.
module calendar_date_arithmetic_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [13:0] in_first_year,
  input  logic [3:0]  in_first_month,
  input  logic [4:0]  in_first_day,
  input  logic [13:0] in_second_year,
  input  logic [3:0]  in_second_month,
  input  logic [4:0]  in_second_day,
  input  logic [15:0] in_day_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_result_year,
  output logic [3:0]  out_result_month,
  output logic [4:0]  out_result_day,
  output logic [21:0] out_distance,
  output logic [1:0]  out_relation,
  output logic        out_range_error
);
  import cda_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DAYS  = 9'b000000010,
    S_FIN   = 9'b000000100,
    S_DIFF  = 9'b000001000,
    S_SHIFT = 9'b000010000,
    S_SPLIT = 9'b000100000,
    S_YCHK  = 9'b001000000,
    S_MONTH = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [1:0]  op_r, op_nxt;
  logic [13:0] y1_r, y1_nxt, y2_r, y2_nxt;
  logic [3:0]  m1_r, m1_nxt, m2_r, m2_nxt;
  logic [4:0]  d1_r, d1_nxt, d2_r, d2_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        sel_b_r, sel_b_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [8:0]  r400_r, r400_nxt;
  logic [8:0]  qb_r, qb_nxt;
  logic        leap_r, leap_nxt;
  logic [DW-1:0] day_a_r, day_a_nxt, day_b_r, day_b_nxt;

  logic [13:0] res_year_r, res_year_nxt;
  logic [3:0]  res_month_r, res_month_nxt;
  logic [4:0]  res_day_r, res_day_nxt;
  logic [21:0] res_dist_r, res_dist_nxt;
  logic [1:0]  res_rel_r, res_rel_nxt;
  logic        res_err_r, res_err_nxt;

  logic [13:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [21:0] out_dist_r;
  logic [1:0]  out_rel_r;
  logic        out_err_r;

  unit_ctl_t   ctl;
  logic [UW-1:0] u_rem, u_acc;
  logic        u_take;

  logic        accept;
  logic        slot_free;
  logic [3:0]  in_m1c, in_m2c;
  logic [1:0]  cmp_rel;
  logic [13:0] cur_y;
  logic [3:0]  cur_m;
  logic [4:0]  cur_d;
  logic        leap_in;
  logic [DW-1:0] base_days, dnum;
  logic [DW-1:0] dn1;
  logic [DW-1:0] a_minus_b, b_minus_a, abs_diff;
  logic [UW-1:0] year_calc;
  step_const_t sc;

  cda_unit u_unit (
    .clk  (clk),
    .ctl  (ctl),
    .rem  (u_rem),
    .acc  (u_acc),
    .take (u_take)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign in_m1c = clamp_month(in_first_month);
  assign in_m2c = clamp_month(in_second_month);

  always_comb begin
    if (in_first_year != in_second_year) begin
      cmp_rel = (in_first_year < in_second_year) ? REL_LT : REL_GT;
    end else if (in_m1c != in_m2c) begin
      cmp_rel = (in_m1c < in_m2c) ? REL_LT : REL_GT;
    end else if (in_first_day != in_second_day) begin
      cmp_rel = (in_first_day < in_second_day) ? REL_LT : REL_GT;
    end else begin
      cmp_rel = REL_EQ;
    end
  end

  assign cur_y = sel_b_r ? y2_r : y1_r;
  assign cur_m = sel_b_r ? m2_r : m1_r;
  assign cur_d = sel_b_r ? d2_r : d1_r;

  // leap test from (year - 1) mod 400; year 0 counts as leap
  assign leap_in = (cur_y == 14'd0) || (r400_r == 9'd399) ||
                   ((r400_r[1:0] == 2'b11) && (r400_r != 9'd99) &&
                    (r400_r != 9'd199) && (r400_r != 9'd299));

  assign base_days = (cur_y == 14'd0) ? '0 : (DW'(u_acc) + DW'(DAYS_TO_Y1));
  assign dnum = base_days + DW'(cum_days(cur_m)) +
                DW'((cur_m > 4'd2) && leap_in) + DW'(cur_d) - DW'(1);

  // day number of the shifted date, counted from 0001-01-01
  assign dn1 = (op_r == OP_ADD) ?
               (day_a_r + DW'(cnt_r) - DW'(DAYS_TO_Y1)) :
               (day_a_r - DW'(cnt_r) - DW'(DAYS_TO_Y1));

  assign a_minus_b = day_a_r - day_b_r;
  assign b_minus_a = day_b_r - day_a_r;
  assign abs_diff  = a_minus_b[DW-1] ? b_minus_a : a_minus_b;

  assign year_calc = u_acc + UW'(1);

  assign sc = step_const(state_r == S_SPLIT, step_r);

  // shared unit control, apart from the state logic that reads take
  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_opcode != OP_CMP)) begin
          ctl.load     = 1'b1;
          ctl.rem_init = UW'(in_first_year) - UW'(1);
        end
      end

      S_DAYS, S_SPLIT: begin
        ctl.step    = 1'b1;
        ctl.divisor = sc.divisor;
        ctl.addend  = sc.addend;
      end

      S_FIN: begin
        if (!sel_b_r && (op_r == OP_DIFF)) begin
          ctl.load     = 1'b1;
          ctl.rem_init = UW'(y2_r) - UW'(1);
        end
      end

      S_SHIFT: begin
        if (!dn1[DW-1]) begin
          ctl.load     = 1'b1;
          ctl.rem_init = dn1[UW-1:0];
        end
      end

      S_YCHK: begin
        if (year_calc <= UW'(YEAR_MAX)) begin
          ctl.load     = 1'b1;
          ctl.rem_init = u_rem;
        end
      end

      S_MONTH: begin
        // the unit only moves on when the month fits
        ctl.divisor = UW'(month_len(u_acc[3:0], leap_r));
        ctl.addend  = UW'(1);
        ctl.step    = (u_acc[3:0] != MONTH_DEC);
      end

      default: begin
        ctl = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    op_nxt        = op_r;
    y1_nxt        = y1_r;
    m1_nxt        = m1_r;
    d1_nxt        = d1_r;
    y2_nxt        = y2_r;
    m2_nxt        = m2_r;
    d2_nxt        = d2_r;
    cnt_nxt       = cnt_r;
    sel_b_nxt     = sel_b_r;
    step_nxt      = step_r;
    r400_nxt      = r400_r;
    qb_nxt        = qb_r;
    leap_nxt      = leap_r;
    day_a_nxt     = day_a_r;
    day_b_nxt     = day_b_r;
    res_year_nxt  = res_year_r;
    res_month_nxt = res_month_r;
    res_day_nxt   = res_day_r;
    res_dist_nxt  = res_dist_r;
    res_rel_nxt   = res_rel_r;
    res_err_nxt   = res_err_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt        = in_opcode;
          y1_nxt        = in_first_year;
          m1_nxt        = in_m1c;
          d1_nxt        = in_first_day;
          y2_nxt        = in_second_year;
          m2_nxt        = in_m2c;
          d2_nxt        = in_second_day;
          cnt_nxt       = in_day_count;
          sel_b_nxt     = 1'b0;
          step_nxt      = '0;
          res_year_nxt  = '0;
          res_month_nxt = '0;
          res_day_nxt   = '0;
          res_dist_nxt  = '0;
          res_rel_nxt   = REL_EQ;
          res_err_nxt   = 1'b0;
          if (in_opcode == OP_CMP) begin
            res_rel_nxt = cmp_rel;
            state_nxt   = S_DONE;
          end else begin
            state_nxt    = (in_first_year == 14'd0) ? S_FIN : S_DAYS;
          end
        end
      end

      S_DAYS: begin
        step_nxt    = step_r + 4'd1;
        // remainder after the 400 year block is the year position in its cycle
        if (step_r == 4'd6) begin
          r400_nxt = u_rem[8:0];
        end
        if (step_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!sel_b_r) begin
          day_a_nxt = dnum;
          if (op_r == OP_DIFF) begin
            sel_b_nxt    = 1'b1;
            step_nxt     = '0;
            state_nxt    = (y2_r == 14'd0) ? S_FIN : S_DAYS;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else begin
          day_b_nxt = dnum;
          state_nxt = S_DIFF;
        end
      end

      S_DIFF: begin
        if (abs_diff > DW'(DIST_MAX)) begin
          res_dist_nxt = 22'(DIST_MAX);
        end else begin
          res_dist_nxt = abs_diff[21:0];
        end
        state_nxt = S_DONE;
      end

      S_SHIFT: begin
        if (dn1[DW-1]) begin
          res_err_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          step_nxt     = '0;
          state_nxt    = S_SPLIT;
        end
      end

      S_SPLIT: begin
        step_nxt    = step_r + 4'd1;
        // keep the quotient bits of the century, 4 year and single year steps
        qb_nxt      = {qb_r[7:0], u_take};
        if (step_r == LAST_STEP) begin
          state_nxt = S_YCHK;
        end
      end

      S_YCHK: begin
        if (year_calc > UW'(YEAR_MAX)) begin
          res_err_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          res_year_nxt = year_calc[13:0];
          leap_nxt     = (qb_r[1:0] == 2'd3) &&
                         ((qb_r[6:2] != 5'd24) || (qb_r[8:7] == 2'd3));
          state_nxt    = S_MONTH;
        end
      end

      S_MONTH: begin
        if (!u_take || (u_acc[3:0] == MONTH_DEC)) begin
          res_month_nxt = u_acc[3:0] + 4'd1;
          res_day_nxt   = u_rem[4:0] + 5'd1;
          state_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    y1_r        <= y1_nxt;
    m1_r        <= m1_nxt;
    d1_r        <= d1_nxt;
    y2_r        <= y2_nxt;
    m2_r        <= m2_nxt;
    d2_r        <= d2_nxt;
    cnt_r       <= cnt_nxt;
    sel_b_r     <= sel_b_nxt;
    step_r      <= step_nxt;
    r400_r      <= r400_nxt;
    qb_r        <= qb_nxt;
    leap_r      <= leap_nxt;
    day_a_r     <= day_a_nxt;
    day_b_r     <= day_b_nxt;
    res_year_r  <= res_year_nxt;
    res_month_r <= res_month_nxt;
    res_day_r   <= res_day_nxt;
    res_dist_r  <= res_dist_nxt;
    res_rel_r   <= res_rel_nxt;
    res_err_r   <= res_err_nxt;
  end

  // output register loads when a finished item moves out
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && slot_free) begin
      out_year_r  <= res_year_r;
      out_month_r <= res_month_r;
      out_day_r   <= res_day_r;
      out_dist_r  <= res_dist_r;
      out_rel_r   <= res_rel_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_year  = out_year_r;
  assign out_result_month = out_month_r;
  assign out_result_day   = out_day_r;
  assign out_distance     = out_dist_r;
  assign out_relation     = out_rel_r;
  assign out_range_error  = out_err_r;

endmodule
